FILE: design/cdp_pkg.sv
// Package for the positional ring-buffer deque.
// Holds the transaction structs, operation and status codes, controller states
// and the command/status bundles. No dependencies.
package cdp_pkg;

   // Parameter defaults
   localparam int CAPACITY_DEF   = 64;
   localparam int DATA_WIDTH_DEF = 32;

   // Fixed field widths of the transactions
   localparam int KIND_W   = 3;
   localparam int POS_W    = 7;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND,
      KIND_INSERT_AT,
      KIND_REMOVE_FRONT,
      KIND_REMOVE_BACK,
      KIND_REMOVE_AT,
      KIND_READ_AT,
      KIND_WRITE_AT,
      KIND_CLEAR
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_BAD_POSITION,
      STATUS_EMPTY,
      STATUS_FULL
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SHIFT,
      ST_APPLY,
      ST_FETCH,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      kind_type                    kind;
      logic [POS_W-1:0]            position;
      logic signed [VALUE_W-1:0]   value;
   } req_type;

   typedef struct packed {
      status_type                  status;
      logic signed [VALUE_W-1:0]   read_value;
      logic [COUNT_W-1:0]          count;
      logic signed [VALUE_W-1:0]   front_value;
      logic signed [VALUE_W-1:0]   back_value;
      logic                        is_empty;
   } rsp_type;

   // Controller to datapath commands, one per controller state
   typedef struct packed {
      logic load;
      logic decode;
      logic shift;
      logic apply;
      logic fetch;
      logic respond;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic need_shift;
      logic shift_last;
   } stat_type;

endpackage

FILE: design/cdp_ram.sv
// Generic simple RAM: one write port, two read ports with registered read data.
// No dependencies.
module cdp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_a_en,
   input  logic [AW-1:0]    rd_a_addr,
   output logic [WIDTH-1:0] rd_a_data,
   input  logic             rd_b_en,
   input  logic [AW-1:0]    rd_b_addr,
   output logic [WIDTH-1:0] rd_b_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write, and register both reads (old data on a same-address collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_data <= mem[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_data <= mem[rd_b_addr];
      end
   end

endmodule

FILE: design/cdp_ctrl.sv
// Controller state machine of the positional deque.
// Depends on cdp_pkg for states and the command/status bundles.
module cdp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  cdp_pkg::stat_type stat,
   output logic              busy,
   output cdp_pkg::cmd_type  cmd
);
   import cdp_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence one transaction: decode, optional shift, apply, fetch ends, respond
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = stat.need_shift ? ST_SHIFT : ST_APPLY;
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.shift_last) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_RESPOND;
         end
         ST_RESPOND: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: design/cdp_datapath.sv
// Datapath of the positional deque: pointers, count, shift engine and storage.
// Depends on cdp_pkg and instantiates cdp_ram for the entry storage.
module cdp_datapath #(
   parameter int CAPACITY   = cdp_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = cdp_pkg::DATA_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cdp_pkg::req_type  req_data,
   input  cdp_pkg::cmd_type  cmd,
   output cdp_pkg::stat_type stat,
   output logic              rsp_valid,
   output cdp_pkg::rsp_type  rsp_data
);
   import cdp_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int SUM_W = CNT_W + 1;

   // Physical slot of a logical index; correct only while both operands stay below CAPACITY
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] logical);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(logical);
      if (sum >= SUM_W'(CAPACITY)) begin
         sum = sum - SUM_W'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] step_fwd(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(CAPACITY - 1)) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? IDX_W'(CAPACITY - 1) : idx - 1'b1;
   endfunction

   function automatic logic [VALUE_W-1:0] to_out(input logic [DATA_WIDTH-1:0] w);
      logic [63:0] w64;
      w64 = 64'(w);
      return w64[VALUE_W-1:0];
   endfunction

   // Control registers
   logic [IDX_W-1:0] head_ff, tail_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] moves_ff, src_ff;
   logic             pend_ff;

   // Payload registers
   req_type               req_ff;
   status_type            status_ff;
   logic [DATA_WIDTH-1:0] read_value_ff;
   logic [IDX_W-1:0]      pend_dst_ff;

   // Storage ports
   logic                  wr_en, rd_a_en, rd_b_en;
   logic [IDX_W-1:0]      wr_addr, rd_a_addr, rd_b_addr;
   logic [DATA_WIDTH-1:0] wr_data, rd_a_data, rd_b_data;

   // Decode signals
   logic [CMP_W-1:0]      count_cmp, pos_cmp;
   logic [CNT_W-1:0]      pos_cnt;
   logic                  is_full, no_entries, is_ok;
   status_type            status_in;
   logic [CNT_W-1:0]      moves_in, src_in;
   logic [DATA_WIDTH-1:0] word;
   logic [63:0]           value64;
   logic [IDX_W-1:0]      pos_slot, src_slot, dst_slot;
   logic                  issue;
   logic [15:0]           count16;

   // Size the request word and position
   always_comb begin
      value64 = {32'b0, req_ff.value};
      word    = value64[DATA_WIDTH-1:0];
      count_cmp = CMP_W'(count_ff);
      pos_cmp   = CMP_W'(req_ff.position);
      pos_cnt   = CNT_W'(pos_cmp);
      is_full    = (count_ff == CNT_W'(CAPACITY));
      no_entries = (count_ff == '0);
      pos_slot   = slot_of(head_ff, pos_cnt);
   end

   // Check the request and size the shift
   always_comb begin
      status_in = STATUS_OK;
      moves_in  = '0;
      src_in    = '0;
      unique case (req_ff.kind)
         KIND_APPEND: begin
            if (is_full) status_in = STATUS_FULL;
         end
         KIND_INSERT_AT: begin
            if (pos_cmp > count_cmp)  status_in = STATUS_BAD_POSITION;
            else if (is_full)         status_in = STATUS_FULL;
            moves_in = count_ff - pos_cnt;
            src_in   = count_ff - 1'b1;
         end
         KIND_REMOVE_FRONT, KIND_REMOVE_BACK: begin
            if (no_entries) status_in = STATUS_EMPTY;
         end
         KIND_REMOVE_AT: begin
            if (pos_cmp >= count_cmp) status_in = STATUS_BAD_POSITION;
            moves_in = count_ff - pos_cnt - 1'b1;
            src_in   = pos_cnt + 1'b1;
         end
         KIND_READ_AT, KIND_WRITE_AT: begin
            if (pos_cmp >= count_cmp) status_in = STATUS_BAD_POSITION;
         end
         KIND_CLEAR: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   assign is_ok = (status_ff == STATUS_OK);

   assign stat.need_shift = (status_in == STATUS_OK) && (moves_in != '0) &&
                            ((req_ff.kind == KIND_INSERT_AT) ||
                             (req_ff.kind == KIND_REMOVE_AT));
   assign stat.shift_last = (moves_ff == '0);

   // Shift engine: read one entry per cycle, write it one slot over in the next cycle
   assign src_slot = slot_of(head_ff, src_ff);
   assign dst_slot = (req_ff.kind == KIND_INSERT_AT) ? step_fwd(src_slot)
                                                     : step_back(src_slot);
   assign issue    = cmd.shift && (moves_ff != '0);

   // Storage port selection
   always_comb begin
      rd_a_en   = issue || cmd.fetch;
      rd_a_addr = cmd.fetch ? head_ff : src_slot;
      rd_b_en   = (cmd.decode && (req_ff.kind == KIND_READ_AT)) || cmd.fetch;
      rd_b_addr = cmd.fetch ? step_back(tail_ff) : pos_slot;
      wr_en     = (cmd.shift && pend_ff) ||
                  (cmd.apply && is_ok && ((req_ff.kind == KIND_APPEND) ||
                                          (req_ff.kind == KIND_INSERT_AT) ||
                                          (req_ff.kind == KIND_WRITE_AT)));
      wr_addr   = cmd.shift ? pend_dst_ff
                            : ((req_ff.kind == KIND_APPEND) ? tail_ff : pos_slot);
      wr_data   = cmd.shift ? rd_a_data : word;
   end

   cdp_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_storage (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_en   (rd_a_en),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (rd_a_data),
      .rd_b_en   (rd_b_en),
      .rd_b_addr (rd_b_addr),
      .rd_b_data (rd_b_data)
   );

   // Pointers, count and shift counters
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         moves_ff <= '0;
         src_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         pend_ff <= issue;
         if (cmd.decode) begin
            moves_ff <= moves_in;
            src_ff   <= src_in;
         end
         if (issue) begin
            moves_ff <= moves_ff - 1'b1;
            src_ff   <= (req_ff.kind == KIND_INSERT_AT) ? src_ff - 1'b1 : src_ff + 1'b1;
         end
         if (cmd.apply && is_ok) begin
            unique case (req_ff.kind)
               KIND_APPEND, KIND_INSERT_AT: begin
                  tail_ff  <= step_fwd(tail_ff);
                  count_ff <= count_ff + 1'b1;
               end
               KIND_REMOVE_FRONT: begin
                  head_ff  <= step_fwd(head_ff);
                  count_ff <= count_ff - 1'b1;
               end
               KIND_REMOVE_BACK, KIND_REMOVE_AT: begin
                  tail_ff  <= step_back(tail_ff);
                  count_ff <= count_ff - 1'b1;
               end
               KIND_CLEAR: begin
                  head_ff  <= '0;
                  tail_ff  <= '0;
                  count_ff <= '0;
               end
               KIND_READ_AT, KIND_WRITE_AT: begin
               end
            endcase
         end
      end
   end

   // Request, verdict and read word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.decode) begin
         status_ff     <= status_in;
         read_value_ff <= '0;
      end
      if (issue) begin
         pend_dst_ff <= dst_slot;
      end
      if (cmd.apply && is_ok && (req_ff.kind == KIND_READ_AT)) begin
         read_value_ff <= rd_b_data;
      end
   end

   // Build the result from the fetched end entries
   assign count16 = 16'(count_ff);
   always_comb begin
      rsp_valid            = cmd.respond;
      rsp_data.status      = status_ff;
      rsp_data.read_value  = to_out(read_value_ff);
      rsp_data.count       = count16[COUNT_W-1:0];
      rsp_data.is_empty    = no_entries;
      rsp_data.front_value = no_entries ? '0 : to_out(rd_a_data);
      rsp_data.back_value  = no_entries ? '0 : to_out(rd_b_data);
   end

endmodule

FILE: design/circular_deque_positional.sv
// Top level of the positional ring-buffer deque.
// Depends on cdp_pkg; instantiates cdp_ctrl and cdp_datapath.
//
// Usage:
//   Request: drive req_data and raise start; the transaction is taken at the
//   rising edge where start is high and busy is low. busy stays high until
//   the result has been shown.
//   Result: rsp_valid is high for exactly one cycle with rsp_data; the
//   receiver cannot stall, so it must take the result in that cycle.
//   Sequence: after the accept edge the controller decodes, then updates
//   pointers and storage, then reads the front and back entries, and then
//   shows the result. Insert and remove at a position that move N entries,
//   N at least one, first run the shift engine before the update
//   (N up to CAPACITY-1), one storage read and one write per moved entry;
//   with nothing to move the shift state is skipped.
//   Reset: synchronous, clears head, tail and count; the deque starts empty.
//   Storage is not cleared; words read from slots without a live entry are masked or dropped.
module circular_deque_positional #(
   parameter int CAPACITY   = cdp_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = cdp_pkg::DATA_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cdp_pkg::req_type req_data,
   output logic             rsp_valid,
   output cdp_pkg::rsp_type rsp_data
);
   import cdp_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   cdp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   cdp_datapath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Check sequencing and result consistency
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepting a transaction");

   a_idle_after_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!busy && !rsp_valid))
      else $error("controller did not return to idle after the result");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.is_empty) |->
         (rsp_data.front_value == 0 && rsp_data.back_value == 0 && rsp_data.count == 0))
      else $error("empty deque reported nonzero ends or count");

   a_reject_no_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_OK) |-> (rsp_data.read_value == 0))
      else $error("rejected transaction returned a read word");

endmodule
